// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define VFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VFC_ASSERT_IMPL(lbl, ante, cons, msg)
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants, codes and types of the voxel face culler.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

    // chunk dimensions
    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 16;
    localparam int SIZE_Z = 16;

    // coordinate fields are 4 bits, so each boundary plane is 16 x 16
    localparam int COORD_W     = 4;
    localparam int COORD_SPAN  = 16;
    localparam int NUM_DIRS    = 6;

    localparam int STORE_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PLANE_DEPTH = NUM_DIRS * COORD_SPAN * COORD_SPAN;
    localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

    localparam int CLEAR_LEN   = (STORE_DEPTH > PLANE_DEPTH) ? STORE_DEPTH : PLANE_DEPTH;
    localparam int CLR_W       = $clog2(CLEAR_LEN);

    localparam int PADDR_W     = 3;

    // register index, taken from paddr[2]
    localparam logic REG_NEIGHBOR_PRESENT = 1'b0;

    // operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PLANE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_MESH  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_FACE = 2'd2;

    // face directions
    localparam logic [2:0] DIR_POS_Y = 3'd0;
    localparam logic [2:0] DIR_NEG_Y = 3'd1;
    localparam logic [2:0] DIR_POS_X = 3'd2;
    localparam logic [2:0] DIR_NEG_X = 3'd3;
    localparam logic [2:0] DIR_POS_Z = 3'd4;
    localparam logic [2:0] DIR_NEG_Z = 3'd5;
    localparam logic [2:0] DIR_NONE  = 3'd6;

    // shade codes
    localparam logic [1:0] SHADE_TOP    = 2'd1;
    localparam logic [1:0] SHADE_SIDE   = 2'd2;
    localparam logic [1:0] SHADE_BOTTOM = 2'd3;

    // result of the neighbor address unit
    typedef struct packed {
        logic                in_chunk;
        logic [STORE_AW-1:0] store_addr;
        logic [PLANE_AW-1:0] plane_addr;
    } nbr_t;

    function automatic logic [1:0] dir_shade(input logic [2:0] dir);
        logic [1:0] s;
        unique case (dir)
            DIR_POS_Y: s = SHADE_TOP;
            DIR_NEG_Y: s = SHADE_BOTTOM;
            default:   s = SHADE_SIDE;
        endcase
        return s;
    endfunction

    // chunk faces that a cell lies on, bit order as the directions
    function automatic logic [NUM_DIRS-1:0] edge_mask(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      input logic [COORD_W-1:0] z);
        logic [NUM_DIRS-1:0] m;
        m[DIR_POS_Y] = ({4'b0000, y} == 8'(SIZE_Y - 1));
        m[DIR_NEG_Y] = (y == '0);
        m[DIR_POS_X] = ({4'b0000, x} == 8'(SIZE_X - 1));
        m[DIR_NEG_X] = (x == '0);
        m[DIR_POS_Z] = ({4'b0000, z} == 8'(SIZE_Z - 1));
        m[DIR_NEG_Z] = (z == '0);
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/vfc_nbr_unit.sv
// ----------------------------------------------------------------------------
// vfc_nbr_unit
// Shared address unit: steps a cell one place in a direction, checks the
// result against the chunk bounds and forms the block store and boundary
// plane addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_nbr_unit (
    input  wire logic [vfc_pkg::COORD_W-1:0] x,
    input  wire logic [vfc_pkg::COORD_W-1:0] y,
    input  wire logic [vfc_pkg::COORD_W-1:0] z,
    input  wire logic [2:0]                  dir,
    output vfc_pkg::nbr_t                    nbr
);

    logic signed [7:0] dx, dy, dz;
    logic signed [7:0] nx, ny, nz;
    logic [vfc_pkg::COORD_W-1:0] u, v;

    always_comb
    begin
        dx = 8'sd0;
        dy = 8'sd0;
        dz = 8'sd0;
        unique case (dir)
            vfc_pkg::DIR_POS_Y: dy = 8'sd1;
            vfc_pkg::DIR_NEG_Y: dy = -8'sd1;
            vfc_pkg::DIR_POS_X: dx = 8'sd1;
            vfc_pkg::DIR_NEG_X: dx = -8'sd1;
            vfc_pkg::DIR_POS_Z: dz = 8'sd1;
            vfc_pkg::DIR_NEG_Z: dz = -8'sd1;
            default: ;  // center cell, no offset
        endcase

        nx = $signed({4'b0000, x}) + dx;
        ny = $signed({4'b0000, y}) + dy;
        nz = $signed({4'b0000, z}) + dz;

        nbr.in_chunk = (nx >= 8'sd0) && (nx < 8'(vfc_pkg::SIZE_X))
                    && (ny >= 8'sd0) && (ny < 8'(vfc_pkg::SIZE_Y))
                    && (nz >= 8'sd0) && (nz < 8'(vfc_pkg::SIZE_Z));

        // only meaningful when in_chunk, then all terms are non-negative
        nbr.store_addr = vfc_pkg::STORE_AW'(nx)
                       + vfc_pkg::STORE_AW'(vfc_pkg::SIZE_X)
                       * (vfc_pkg::STORE_AW'(ny)
                          + vfc_pkg::STORE_AW'(vfc_pkg::SIZE_Y) * vfc_pkg::STORE_AW'(nz));

        // plane coordinates are the two axes off the plane normal
        if (dir < vfc_pkg::DIR_POS_X)
        begin
            u = x;
            v = z;
        end
        else if (dir < vfc_pkg::DIR_POS_Z)
        begin
            u = y;
            v = z;
        end
        else
        begin
            u = x;
            v = y;
        end
        nbr.plane_addr = vfc_pkg::PLANE_AW'({dir, v, u});
    end

endmodule

`default_nettype wire

// File: hw/rtl/voxel_face_culler_core.sv
// ----------------------------------------------------------------------------
// voxel_face_culler_core
// Voxel chunk store with boundary planes and per-cell face culling.
// ----------------------------------------------------------------------------
// After reset the block clears its block store and boundary planes one entry
// per cycle, over max(SIZE_X*SIZE_Y*SIZE_Z, 1536) entries (4096 at 16^3), with
// in_ready low; configuration writes are taken meanwhile. It then works on
// one item at a time. A write passes through EXEC and a read through EXEC and
// RDWAIT before its result is registered in the output register; the state
// that forms the result waits while the output is stalled. A mesh query walks
// the six neighbors through one shared address unit and the single read port
// of each memory, one neighbor per cycle, and then emits each uncovered face
// in turn, waiting while the output stalls; an air cell ends without faces.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module voxel_face_culler_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // apb configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vfc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,

    // input items
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    op,
    input  wire logic [vfc_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [vfc_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [vfc_pkg::COORD_W-1:0]   pos_z,
    input  wire logic [7:0]                    block_value,
    input  wire logic [2:0]                    plane_side,

    // result items
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [1:0]                    kind,
    output logic      [2:0]                    face_dir,
    output logic      [1:0]                    shade,
    output logic      [vfc_pkg::COORD_W-1:0]   out_x,
    output logic      [vfc_pkg::COORD_W-1:0]   out_y,
    output logic      [vfc_pkg::COORD_W-1:0]   out_z,
    output logic      [7:0]                    read_value,
    output logic      [vfc_pkg::NUM_DIRS-1:0]  neighbor_mark,
    output logic                               last
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // scan count at which the last neighbor is checked
    localparam logic [2:0] SCAN_END  = 3'(vfc_pkg::NUM_DIRS);

    typedef struct packed {
        logic [1:0]                   kind;
        logic [2:0]                   face_dir;
        logic [1:0]                   shade;
        logic [vfc_pkg::COORD_W-1:0]  x;
        logic [vfc_pkg::COORD_W-1:0]  y;
        logic [vfc_pkg::COORD_W-1:0]  z;
        logic [7:0]                   read_value;
        logic [vfc_pkg::NUM_DIRS-1:0] neighbor_mark;
        logic                         last;
    } res_t;

    logic [2:0]                    state_reg, state_next;
    logic [vfc_pkg::CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [2:0]                    cnt_reg, cnt_next;
    logic [vfc_pkg::NUM_DIRS-1:0]  mask_reg, mask_next;
    logic                          center_in_reg, center_in_next;
    logic                          nbr_in_reg, nbr_in_next;
    logic [vfc_pkg::NUM_DIRS-1:0]  present_reg;

    logic [1:0]                    op_reg, op_next;
    logic [vfc_pkg::COORD_W-1:0]   x_reg, x_next;
    logic [vfc_pkg::COORD_W-1:0]   y_reg, y_next;
    logic [vfc_pkg::COORD_W-1:0]   z_reg, z_next;
    logic [7:0]                    val_reg, val_next;
    logic [2:0]                    side_reg, side_next;

    logic                          out_valid_reg, out_valid_next;
    res_t                          res_reg, res_next;

    logic                          slot_free;
    logic [2:0]                    unit_dir;
    vfc_pkg::nbr_t                 nbr;

    logic                          store_we, store_re;
    logic [vfc_pkg::STORE_AW-1:0]  store_waddr;
    logic [7:0]                    store_wdata, store_rd;
    logic                          plane_we, plane_re;
    logic [vfc_pkg::PLANE_AW-1:0]  plane_waddr;
    logic                          plane_wdata;
    logic [0:0]                    plane_rd;

    logic [2:0]                    chk_dir;
    logic                          covered;
    logic [vfc_pkg::NUM_DIRS-1:0]  mask_found;
    logic [2:0]                    low_dir;
    logic [vfc_pkg::NUM_DIRS-1:0]  mask_left;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == vfc_pkg::REG_NEIGHBOR_PRESENT))
        begin
            present_reg <= pwdata[vfc_pkg::NUM_DIRS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == vfc_pkg::REG_NEIGHBOR_PRESENT)
        begin
            prdata = 32'(present_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // shared address unit and memories
    // ------------------------------------------------------------------
    vfc_nbr_unit u_nbr (
        .x   (x_reg),
        .y   (y_reg),
        .z   (z_reg),
        .dir (unit_dir),
        .nbr (nbr)
    );

    vfc_ram #(
        .DEPTH (vfc_pkg::STORE_DEPTH),
        .WIDTH (8),
        .AW    (vfc_pkg::STORE_AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (nbr.store_addr),
        .rdata (store_rd)
    );

    vfc_ram #(
        .DEPTH (vfc_pkg::PLANE_DEPTH),
        .WIDTH (1),
        .AW    (vfc_pkg::PLANE_AW)
    ) u_planes (
        .clk   (clk),
        .we    (plane_we),
        .waddr (plane_waddr),
        .wdata (plane_wdata),
        .re    (plane_re),
        .raddr (nbr.plane_addr),
        .rdata (plane_rd)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // neighbor checked in this scan cycle was issued in the scan cycle before
    assign chk_dir = cnt_reg - 3'd1;

    always_comb
    begin
        low_dir = '0;
        for (int i = vfc_pkg::NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_dir = 3'(i);
            end
        end
        mask_left = mask_reg & ~(vfc_pkg::NUM_DIRS'(1) << low_dir);
    end

    always_comb
    begin
        // past the chunk edge only a present neighbor with a solid plane cell covers
        if (nbr_in_reg)
        begin
            covered = (store_rd != 8'd0);
        end
        else
        begin
            covered = present_reg[chk_dir] && plane_rd[0];
        end
        mask_found = mask_reg;
        if (!covered)
        begin
            mask_found = mask_reg | (vfc_pkg::NUM_DIRS'(1) << chk_dir);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        center_in_next = center_in_reg;
        nbr_in_next    = nbr_in_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        val_next       = val_reg;
        side_next      = side_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        unit_dir    = vfc_pkg::DIR_NONE;
        store_we    = 1'b0;
        store_waddr = nbr.store_addr;
        store_wdata = val_reg;
        store_re    = 1'b0;
        plane_we    = 1'b0;
        plane_waddr = nbr.plane_addr;
        plane_wdata = (val_reg != 8'd0);
        plane_re    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                store_we    = (int'(clr_cnt_reg) < vfc_pkg::STORE_DEPTH);
                store_waddr = vfc_pkg::STORE_AW'(clr_cnt_reg);
                store_wdata = '0;
                plane_we    = (int'(clr_cnt_reg) < vfc_pkg::PLANE_DEPTH);
                plane_waddr = vfc_pkg::PLANE_AW'(clr_cnt_reg);
                plane_wdata = 1'b0;
                if (clr_cnt_reg == vfc_pkg::CLR_W'(vfc_pkg::CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    x_next     = pos_x;
                    y_next     = pos_y;
                    z_next     = pos_z;
                    val_next   = block_value;
                    side_next  = plane_side;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (op_reg == vfc_pkg::OP_PLANE)
                begin
                    unit_dir = side_reg;
                end
                center_in_next = nbr.in_chunk;
                unique case (op_reg)
                    vfc_pkg::OP_WRITE:
                    begin
                        if (slot_free)
                        begin
                            store_we       = nbr.in_chunk;
                            out_valid_next = 1'b1;
                            res_next       = '{kind: vfc_pkg::KIND_ACK, face_dir: '0,
                                               shade: '0, x: x_reg, y: y_reg, z: z_reg,
                                               read_value: '0,
                                               neighbor_mark: nbr.in_chunk
                                                   ? (vfc_pkg::edge_mask(x_reg, y_reg, z_reg)
                                                      & present_reg)
                                                   : '0,
                                               last: 1'b1};
                            state_next     = ST_IDLE;
                        end
                    end
                    vfc_pkg::OP_PLANE:
                    begin
                        if (slot_free)
                        begin
                            plane_we       = (side_reg < 3'(vfc_pkg::NUM_DIRS));
                            out_valid_next = 1'b1;
                            res_next       = '{kind: vfc_pkg::KIND_ACK, face_dir: '0,
                                               shade: '0, x: x_reg, y: y_reg, z: z_reg,
                                               read_value: '0,
                                               neighbor_mark: '0, last: 1'b1};
                            state_next     = ST_IDLE;
                        end
                    end
                    vfc_pkg::OP_READ:
                    begin
                        store_re   = nbr.in_chunk;
                        state_next = ST_RDWAIT;
                    end
                    vfc_pkg::OP_MESH:
                    begin
                        store_re   = nbr.in_chunk;
                        cnt_next   = '0;
                        mask_next  = '0;
                        state_next = ST_SCAN;
                    end
                    default: ;
                endcase
            end

            ST_RDWAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '{kind: vfc_pkg::KIND_READ, face_dir: '0, shade: '0,
                                       x: x_reg, y: y_reg, z: z_reg,
                                       read_value: center_in_reg ? store_rd : 8'd0,
                                       neighbor_mark: '0, last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue neighbor cnt while checking neighbor cnt-1
                if (cnt_reg < SCAN_END)
                begin
                    unit_dir    = cnt_reg;
                    store_re    = nbr.in_chunk;
                    plane_re    = 1'b1;
                    nbr_in_next = nbr.in_chunk;
                end
                if (cnt_reg == '0)
                begin
                    // air or out-of-chunk cell gives no faces
                    if (!center_in_reg || (store_rd == 8'd0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                else
                begin
                    mask_next = mask_found;
                    if (cnt_reg == SCAN_END)
                    begin
                        if (mask_found == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '{kind: vfc_pkg::KIND_FACE, face_dir: low_dir,
                                       shade: vfc_pkg::dir_shade(low_dir),
                                       x: x_reg, y: y_reg, z: z_reg, read_value: '0,
                                       neighbor_mark: '0, last: (mask_left == '0)};
                    mask_next      = mask_left;
                    if (mask_left == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            center_in_reg <= 1'b0;
            nbr_in_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            center_in_reg <= center_in_next;
            nbr_in_reg    <= nbr_in_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        val_reg  <= val_next;
        side_reg <= side_next;
        res_reg  <= res_next;
    end

    // coordinates travel with each result item, so a new item cannot disturb them
    assign out_valid     = out_valid_reg;
    assign kind          = res_reg.kind;
    assign face_dir      = res_reg.face_dir;
    assign shade         = res_reg.shade;
    assign out_x         = res_reg.x;
    assign out_y         = res_reg.y;
    assign out_z         = res_reg.z;
    assign read_value    = res_reg.read_value;
    assign neighbor_mark = res_reg.neighbor_mark;
    assign last          = res_reg.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `VFC_ASSERT_IMPL(a_no_store_write_in_mesh, (state_reg == ST_SCAN) || (state_reg == ST_EMIT), !store_we, "store written during a mesh query")
    `VFC_ASSERT_IMPL(a_emit_mask_nonempty, state_reg == ST_EMIT, mask_reg != '0, "face emit with empty mask")
    `VFC_ASSERT_IMPL(a_scan_count_bound, state_reg == ST_SCAN, cnt_reg <= SCAN_END, "scan count past last direction")
    `VFC_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_reg == ST_EXEC, "accepted item not executed")
    `VFC_ASSERT_NEXT(a_emit_fills_slot, (state_reg == ST_EMIT) && slot_free, out_valid_reg && (res_reg.kind == vfc_pkg::KIND_FACE), "face not placed in output register")

endmodule

`default_nettype wire
